FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/toptr_pkg.sv
// Types and constants of the two-opt tour refiner.
`default_nettype none
package toptr_pkg;
   localparam int MAX_CITIES = 32;

   localparam logic [1:0] OP_DIST = 2'd0;
   localparam logic [1:0] OP_TOUR = 2'd1;
   localparam logic [1:0] OP_RUN  = 2'd2;
   localparam logic       CSR_MAX_PASSES  = 1'b0;
   localparam logic       CSR_TOUR_LENGTH = 1'b1;

   // Tour operand slots of one pair.
   localparam logic [1:0] TS_PREV = 2'd0;   // t[i-1]
   localparam logic [1:0] TS_I    = 2'd1;   // t[i]
   localparam logic [1:0] TS_J    = 2'd2;   // t[j]
   localparam logic [1:0] TS_NEXT = 2'd3;   // t[j+1]

   // Distance lookups of one pair.
   localparam logic [1:0] DS_CUR_I = 2'd0;  // d(t[i-1], t[i])
   localparam logic [1:0] DS_CUR_J = 2'd1;  // d(t[j], t[j+1])
   localparam logic [1:0] DS_ALT_I = 2'd2;  // d(t[i-1], t[j])
   localparam logic [1:0] DS_ALT_J = 2'd3;  // d(t[i], t[j+1])

   typedef enum logic [4:0] {
      ST_IDLE, ST_PASS, ST_PAIR, ST_RA, ST_RB, ST_RC, ST_RD, ST_DA, ST_DB, ST_DC,
      ST_DD, ST_DE, ST_CMP, ST_SWA, ST_SWB, ST_SWC, ST_NEXT, ST_OUTA, ST_OUTB
   } state_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic       init_run;   // clear pass count, set improved
      logic       start_pass; // clear improved, bump pass count, i=1
      logic       start_pair; // not set by the controller nor used by the datapath
      logic [1:0] tour_sel;   // which tour slot to read
      logic       tour_cap;   // capture tour read data into the slot read last cycle
      logic [1:0] dist_sel;   // which distance to read
      logic       dist_cap;   // capture distance into the slot read last cycle
      logic       sw_rd_lo;   // read t[lo] for swap
      logic       sw_rd_hi;   // capture lo, read t[hi]
      logic       start_rev;  // lo=i, hi=j, set improved
      logic       next_j;
      logic       next_i;
      logic       out_init;
      logic       out_rd;
      logic       out_emit;
   } cmd_type;

   typedef struct packed {
      logic pass_go;   // improved and pass_count < max_passes
      logic i_ok;      // i + 2 < len
      logic j_ok;      // j + 1 < len
      logic better;    // alt < cur
      logic rev_more;  // lo < hi
      logic out_more;  // k < len
   } status_type;
endpackage
`default_nettype wire

FILE: rtl/toptr_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module toptr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/toptr_ctrl.sv
// Controller state machine of the two-opt tour refiner.
`default_nettype none
module toptr_ctrl import toptr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       go,
   input  wire status_type sts,
   output cmd_type         cmd,
   output logic            busy
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (go) begin
               cmd.init_run = 1'b1;
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            if (sts.pass_go) begin
               cmd.start_pass = 1'b1;
               state_in = ST_PAIR;
            end else begin
               cmd.out_init = 1'b1;
               state_in = ST_OUTA;
            end
         end
         ST_PAIR: begin
            if (!sts.i_ok) begin
               state_in = ST_PASS;
            end else if (!sts.j_ok) begin
               cmd.next_i = 1'b1;
            end else begin
               cmd.tour_sel = TS_PREV;
               state_in = ST_RA;
            end
         end
         // Each read state captures the data addressed in the state before it.
         ST_RA: begin
            cmd.tour_sel = TS_I;
            cmd.tour_cap = 1'b1;
            state_in = ST_RB;
         end
         ST_RB: begin
            cmd.tour_sel = TS_J;
            cmd.tour_cap = 1'b1;
            state_in = ST_RC;
         end
         ST_RC: begin
            cmd.tour_sel = TS_NEXT;
            cmd.tour_cap = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            cmd.tour_cap = 1'b1;
            state_in = ST_DA;
         end
         ST_DA: begin
            cmd.dist_sel = DS_CUR_I;
            state_in = ST_DB;
         end
         ST_DB: begin
            cmd.dist_sel = DS_CUR_J;
            cmd.dist_cap = 1'b1;
            state_in = ST_DC;
         end
         ST_DC: begin
            cmd.dist_sel = DS_ALT_I;
            cmd.dist_cap = 1'b1;
            state_in = ST_DD;
         end
         ST_DD: begin
            cmd.dist_sel = DS_ALT_J;
            cmd.dist_cap = 1'b1;
            state_in = ST_DE;
         end
         ST_DE: begin
            cmd.dist_cap = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.better) begin
               cmd.start_rev = 1'b1;
               state_in = ST_SWA;
            end else begin
               cmd.next_j = 1'b1;
               state_in = ST_PAIR;
            end
         end
         ST_SWA: begin
            if (sts.rev_more) begin
               cmd.sw_rd_lo = 1'b1;
               state_in = ST_SWB;
            end else begin
               cmd.next_j = 1'b1;
               state_in = ST_PAIR;
            end
         end
         ST_SWB: begin
            cmd.sw_rd_hi = 1'b1;
            state_in = ST_SWC;
         end
         // The datapath writes t[lo] here and t[hi] in the next state.
         ST_SWC: begin
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ST_SWA;
         end
         ST_OUTA: begin
            if (sts.out_more) begin
               cmd.out_rd = 1'b1;
               state_in = ST_OUTB;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTB: begin
            cmd.out_emit = 1'b1;
            state_in = ST_OUTA;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/toptr_dp.sv
// Datapath of the two-opt tour refiner: stores, pointers and cost compare.
`default_nettype none
module toptr_dp import toptr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic        ld_dist,
   input  wire logic        ld_tour,
   input  wire logic [5:0]  row_city,
   input  wire logic [5:0]  col_city,
   input  wire logic [15:0] dist_value,
   input  wire logic [5:0]  tour_pos,
   input  wire logic [5:0]  tour_city,
   input  wire logic [15:0] max_passes,
   input  wire logic [6:0]  len,
   output status_type       sts,
   output logic             out_valid,
   output logic [5:0]       out_pos,
   output logic [5:0]       out_city,
   output logic             out_last
);
   localparam int TD = MAX_CITIES + 1;
   localparam int TAW = $clog2(TD);
   localparam int CW = $clog2(MAX_CITIES);
   localparam int DAW = 2 * CW;
   localparam int DD = MAX_CITIES * MAX_CITIES;

   logic [6:0]  i_ff, j_ff, lo_ff, hi_ff, k_ff;
   logic [15:0] pass_ff;
   logic        impr_ff;
   logic [5:0]  c_ff [4];
   logic [15:0] d_ff [4];
   logic        dz_ff, dz_in;
   logic [5:0]  tmp_ff;
   logic [1:0]  dsel_ff;
   logic [1:0]  tsel_ff;

   // tour RAM
   logic          t_we;
   logic [6:0]    t_a7;
   logic [5:0]    t_wd, t_rd;
   always_comb begin
      t_we = 1'b0;
      t_wd = tour_city;
      t_a7 = {1'b0, tour_pos};
      if (ld_tour) begin
         t_we = ({1'b0, tour_pos} < 7'(TD));
      end else if (cmd.sw_rd_lo) begin
         t_a7 = lo_ff;
      end else if (cmd.sw_rd_hi) begin
         t_a7 = hi_ff;
      end else if (cmd.out_rd) begin
         t_a7 = k_ff;
      end else begin
         case (cmd.tour_sel)
            TS_PREV: t_a7 = i_ff - 7'd1;
            TS_I:    t_a7 = i_ff;
            TS_J:    t_a7 = j_ff;
            default: t_a7 = j_ff + 7'd1;
         endcase
      end
   end

   // swap write port shares the RAM: write occurs in the cycles after reads
   typedef enum logic [1:0] {SW_NONE, SW_LO, SW_HI} sw_type;
   sw_type sw_ff;
   logic          ram_we;
   logic [TAW-1:0] ram_a;
   logic [5:0]    ram_wd;
   always_comb begin
      ram_we = t_we;
      ram_a = t_a7[TAW-1:0];
      ram_wd = t_wd;
      if (sw_ff == SW_LO) begin
         ram_we = 1'b1;
         ram_a = lo_ff[TAW-1:0];
         ram_wd = t_rd;
      end else if (sw_ff == SW_HI) begin
         ram_we = 1'b1;
         ram_a = hi_ff[TAW-1:0];
         ram_wd = tmp_ff;
      end
   end

   toptr_ram #(.WIDTH(6), .DEPTH(TD)) u_tour (
      .clock(clock), .wr_en(ram_we), .addr(ram_a), .wr_data(ram_wd), .rd_data(t_rd)
   );

   // distance RAM
   logic          dm_we;
   logic [DAW-1:0] dm_a;
   logic [15:0]   dm_rd;
   logic [5:0]    ra, rb;
   always_comb begin
      dm_we = 1'b0;
      ra = row_city;
      rb = col_city;
      if (ld_dist) begin
         dm_we = ({1'b0, row_city} < 7'(MAX_CITIES)) && ({1'b0, col_city} < 7'(MAX_CITIES));
      end else begin
         case (cmd.dist_sel)
            DS_CUR_I: begin ra = c_ff[0]; rb = c_ff[1]; end
            DS_CUR_J: begin ra = c_ff[2]; rb = c_ff[3]; end
            DS_ALT_I: begin ra = c_ff[0]; rb = c_ff[2]; end
            default:  begin ra = c_ff[1]; rb = c_ff[3]; end
         endcase
      end
      dm_a = {ra[CW-1:0], rb[CW-1:0]};
      dz_in = ({1'b0, ra} >= 7'(MAX_CITIES)) || ({1'b0, rb} >= 7'(MAX_CITIES));
   end

   toptr_ram #(.WIDTH(16), .DEPTH(DD)) u_dist (
      .clock(clock), .wr_en(dm_we), .addr(dm_a), .wr_data(dist_value), .rd_data(dm_rd)
   );

   // costs
   logic [16:0] cur, alt;
   assign cur = {1'b0, d_ff[0]} + {1'b0, d_ff[1]};
   assign alt = {1'b0, d_ff[2]} + {1'b0, d_ff[3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
         impr_ff <= 1'b0;
         sw_ff <= SW_NONE;
         out_valid <= 1'b0;
      end else begin
         if (cmd.init_run) begin
            pass_ff <= '0;
            impr_ff <= 1'b1;
         end
         if (cmd.start_pass) begin
            pass_ff <= pass_ff + 16'd1;
            impr_ff <= 1'b0;
         end
         if (cmd.start_rev) begin
            impr_ff <= 1'b1;
         end
         if (cmd.sw_rd_hi) begin
            sw_ff <= SW_LO;
         end else if (sw_ff == SW_LO) begin
            sw_ff <= SW_HI;
         end else begin
            sw_ff <= SW_NONE;
         end
         out_valid <= cmd.out_emit;
      end
   end

   always_ff @(posedge clock) begin
      dsel_ff <= cmd.dist_sel;
      tsel_ff <= cmd.tour_sel;
      dz_ff <= dz_in;
      if (cmd.start_pass) begin
         i_ff <= 7'd1;
         j_ff <= 7'd2;
      end
      if (cmd.next_i) begin
         i_ff <= i_ff + 7'd1;
         j_ff <= i_ff + 7'd2;
      end
      if (cmd.next_j) begin
         j_ff <= j_ff + 7'd1;
      end
      if (cmd.tour_cap) begin
         c_ff[tsel_ff] <= t_rd;
      end
      if (cmd.dist_cap) begin
         d_ff[dsel_ff] <= dz_ff ? 16'd0 : dm_rd;
      end
      if (cmd.start_rev) begin
         lo_ff <= i_ff;
         hi_ff <= j_ff;
      end
      if (cmd.sw_rd_hi) begin
         tmp_ff <= t_rd;
      end
      if (sw_ff == SW_HI) begin
         lo_ff <= lo_ff + 7'd1;
         hi_ff <= hi_ff - 7'd1;
      end
      if (cmd.out_init) begin
         k_ff <= '0;
      end
      if (cmd.out_rd) begin
         out_pos <= k_ff[5:0];
         out_last <= (k_ff + 7'd1 == len);
         k_ff <= k_ff + 7'd1;
      end
      if (cmd.out_emit) begin
         out_city <= t_rd;
      end
   end

   assign sts.pass_go = impr_ff && (pass_ff < max_passes);
   assign sts.i_ok = (i_ff + 7'd2 < len);
   assign sts.j_ok = (j_ff + 7'd1 < len);
   assign sts.better = alt < cur;
   assign sts.rev_more = (lo_ff < hi_ff);
   assign sts.out_more = (k_ff < len);
endmodule
`default_nettype wire

FILE: rtl/two_opt_tour_refiner.sv
// Top level of the two-opt tour refiner.
`default_nettype none
// Usage: a command beat is taken when start is high and busy is low.
// Opcode 0 writes one distance entry and opcode 1 writes one tour entry;
// each load leaves busy low, so loads can follow back to back. Opcode 2
// runs the 2-opt search: each pass starts, steps through i and j and
// closes, and each (i, j) pair reads its four tour entries and then its
// four distances through the single-port tour and distance memories
// before the costs are compared. An improving pair then reverses its
// segment, reading each swapped element pair and writing it back.
// Passes repeat while the last pass improved, up to max_passes. The run
// then streams the tour as result beats, marked by rsp_valid, with
// rsp_last on the final entry. The receiver cannot stall results. Busy
// rises the cycle after the run beat and falls the cycle after the last
// result beat. Reset returns the controller to idle and loads
// max_passes=100 and tour_length=33; the memories keep undefined contents
// until written. Configuration writes are taken whenever csr_we is high;
// they are meant to happen while busy is low.
`include "assert_macros.svh"
module two_opt_tour_refiner import toptr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [5:0]  req_row_city,
   input  wire logic [5:0]  req_col_city,
   input  wire logic [15:0] req_dist_value,
   input  wire logic [5:0]  req_tour_pos,
   input  wire logic [5:0]  req_tour_city,
   output logic             rsp_valid,
   output logic [5:0]       rsp_out_pos,
   output logic [5:0]       rsp_out_city,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   logic [15:0] max_passes_ff;
   logic [6:0]  tour_length_ff;
   logic [6:0]  len;
   logic        accept;
   cmd_type     cmd;
   status_type  sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_passes_ff <= 16'd100;
         tour_length_ff <= 7'd33;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_PASSES: max_passes_ff <= csr_wdata;
            CSR_TOUR_LENGTH: tour_length_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Lengths beyond the tour store saturate to its depth.
   assign len = (tour_length_ff > 7'(MAX_CITIES + 1)) ? 7'(MAX_CITIES + 1) : tour_length_ff;
   assign accept = start && !busy;

   toptr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .go(accept && (req_opcode == OP_RUN)),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   toptr_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .ld_dist(accept && (req_opcode == OP_DIST)),
      .ld_tour(accept && (req_opcode == OP_TOUR)),
      .row_city(req_row_city), .col_city(req_col_city), .dist_value(req_dist_value),
      .tour_pos(req_tour_pos), .tour_city(req_tour_city),
      .max_passes(max_passes_ff), .len(len), .sts(sts),
      .out_valid(rsp_valid), .out_pos(rsp_out_pos), .out_city(rsp_out_city),
      .out_last(rsp_last)
   );

   // Results only appear while a run is in progress.
   `ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, busy, "result beat while idle")
   // The final result beat ends the run.
   `ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_last, !busy, "busy after last beat")
   // A load never starts the sequencer.
   `ASSERT_NEXT(a_load_idle, clock, reset, accept && (req_opcode != OP_RUN), !busy, "load set busy")
endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for the two-opt tour refiner.
`default_nettype none
module testbench import toptr_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CITIES = 32;
   localparam int TOUR_SLOTS = NUM_CITIES + 1;
   localparam int USED_CITIES = 6;          // cities that tours visit inside the matrix
   localparam logic [1:0] OP_NONE = 2'd3;   // unused opcode, ignored by the block
   localparam int SETTLE_CYCLES = 8;        // quiet cycles before a register write
   localparam int STALL_LIMIT = 20000000;   // cycles without any accepted beat

   typedef enum logic [1:0] {K_ITEM, K_CSR, K_DRAIN, K_IDLE} entry_kind_type;

   // One entry of the stimulus script: a command beat, a register write,
   // a pause until the block has gone quiet, or a change of sender idling.
   typedef struct {
      entry_kind_type kind;
      logic [1:0]  opcode;
      logic [5:0]  row_city;
      logic [5:0]  col_city;
      logic [15:0] dist_value;
      logic [5:0]  tour_pos;
      logic [5:0]  tour_city;
      logic        csr_idx;
      logic [15:0] csr_data;
      int          idle_pct;
   } script_entry_type;

   typedef struct {
      logic [5:0] pos;
      logic [5:0] city;
      logic       last;
   } tour_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [5:0]  req_row_city = '0;
   logic [5:0]  req_col_city = '0;
   logic [15:0] req_dist_value = '0;
   logic [5:0]  req_tour_pos = '0;
   logic [5:0]  req_tour_city = '0;
   logic        rsp_valid;
   logic [5:0]  rsp_out_pos;
   logic [5:0]  rsp_out_city;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   // Pending stimulus and tour beats still owed by the block.
   script_entry_type pending_script[$];
   tour_beat_type    expected_tour[$];
   int          mismatch_count = 0;

   // Shadow copy of the block's storage and registers.
   logic [15:0] dist_shadow[NUM_CITIES][NUM_CITIES];
   logic [5:0]  tour_shadow[TOUR_SLOTS];
   logic [15:0] max_passes_shadow = 16'd100;
   logic [6:0]  tour_len_shadow = 7'd33;

   two_opt_tour_refiner dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_row_city(req_row_city),
      .req_col_city(req_col_city), .req_dist_value(req_dist_value),
      .req_tour_pos(req_tour_pos), .req_tour_city(req_tour_city),
      .rsp_valid(rsp_valid), .rsp_out_pos(rsp_out_pos),
      .rsp_out_city(rsp_out_city), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Cities outside the matrix contribute a distance of zero.
   function automatic int unsigned edge_cost(logic [5:0] a, logic [5:0] b);
      if (a >= NUM_CITIES || b >= NUM_CITIES) return 0;
      return dist_shadow[a][b];
   endfunction

   // Runs the 2-opt search on the shadow tour and queues the resulting beats.
   // Each improving pair reverses its segment at once, so the sweep keeps
   // going over the already changed tour.
   function automatic void refine_tour();
      int unsigned len;
      int unsigned passes;
      int unsigned cur_cost;
      int unsigned alt_cost;
      int unsigned lo;
      int unsigned hi;
      logic [5:0]  swap_city;
      bit          improved;
      tour_beat_type beat;
      len = (tour_len_shadow > TOUR_SLOTS) ? TOUR_SLOTS : tour_len_shadow;
      passes = 0;
      improved = 1'b1;
      while (improved && passes < max_passes_shadow) begin
         improved = 1'b0;
         passes++;
         for (int unsigned i = 1; i + 2 < len; i++) begin
            for (int unsigned j = i + 1; j + 1 < len; j++) begin
               cur_cost = edge_cost(tour_shadow[i-1], tour_shadow[i]) +
                          edge_cost(tour_shadow[j], tour_shadow[j+1]);
               alt_cost = edge_cost(tour_shadow[i-1], tour_shadow[j]) +
                          edge_cost(tour_shadow[i], tour_shadow[j+1]);
               if (alt_cost < cur_cost) begin
                  lo = i;
                  hi = j;
                  while (lo < hi) begin
                     swap_city = tour_shadow[lo];
                     tour_shadow[lo] = tour_shadow[hi];
                     tour_shadow[hi] = swap_city;
                     lo++;
                     hi--;
                  end
                  improved = 1'b1;
               end
            end
         end
      end
      for (int unsigned k = 0; k < len; k++) begin
         beat.pos = k[5:0];
         beat.city = tour_shadow[k];
         beat.last = (k + 1 == len);
         expected_tour = {expected_tour, beat};
      end
   endfunction

   // Applies one accepted command beat to the shadow state.
   function automatic void apply_command(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                         logic [15:0] value, logic [5:0] pos,
                                         logic [5:0] city);
      case (op)
         OP_DIST: begin
            if (row < NUM_CITIES && col < NUM_CITIES) dist_shadow[row][col] = value;
         end
         OP_TOUR: begin
            if (pos < TOUR_SLOTS) tour_shadow[pos] = city;
         end
         OP_RUN: begin
            refine_tour();
         end
         default: ;
      endcase
   endfunction

   function automatic script_entry_type blank_entry(entry_kind_type kind);
      script_entry_type e;
      e.kind = kind;
      e.opcode = OP_NONE;
      e.row_city = 6'($urandom);
      e.col_city = 6'($urandom);
      e.dist_value = 16'($urandom);
      e.tour_pos = 6'($urandom);
      e.tour_city = 6'($urandom);
      e.csr_idx = 1'b0;
      e.csr_data = '0;
      e.idle_pct = 0;
      return e;
   endfunction

   // Tours only visit the loaded corner of the matrix or cities beyond it.
   function automatic logic [5:0] random_city();
      if ($urandom_range(7) == 0) return 6'($urandom_range(63, NUM_CITIES));
      return 6'($urandom_range(USED_CITIES - 1));
   endfunction

   // Unused fields of a command carry random junk, which the block must ignore.
   task automatic queue_command(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                logic [15:0] value, logic [5:0] pos, logic [5:0] city);
      script_entry_type e;
      e = blank_entry(K_ITEM);
      e.opcode = op;
      if (op == OP_DIST) begin
         e.row_city = row;
         e.col_city = col;
         e.dist_value = value;
      end
      if (op == OP_TOUR) begin
         e.tour_pos = pos;
         e.tour_city = city;
      end
      pending_script = {pending_script, e};
   endtask

   // Distances are always written in symmetric pairs. With a symmetric matrix
   // every reversal strictly shortens the tour, so each run terminates quickly
   // even with a huge pass limit.
   task automatic queue_distance(logic [5:0] a, logic [5:0] b, logic [15:0] value);
      queue_command(OP_DIST, a, b, value, 6'd0, 6'd0);
      if (a != b) queue_command(OP_DIST, b, a, value, 6'd0, 6'd0);
   endtask

   task automatic queue_tour(logic [5:0] pos, logic [5:0] city);
      queue_command(OP_TOUR, 6'd0, 6'd0, 16'd0, pos, city);
   endtask

   task automatic queue_run();
      queue_command(OP_RUN, 6'd0, 6'd0, 16'd0, 6'd0, 6'd0);
   endtask

   // Registers change only once the block has gone quiet.
   task automatic queue_setting(logic [15:0] passes, logic [15:0] len);
      script_entry_type e;
      pending_script = {pending_script, blank_entry(K_DRAIN)};
      e = blank_entry(K_CSR);
      e.csr_idx = CSR_MAX_PASSES;
      e.csr_data = passes;
      pending_script = {pending_script, e};
      e.csr_idx = CSR_TOUR_LENGTH;
      e.csr_data = len;
      pending_script = {pending_script, e};
   endtask

   task automatic queue_idle(int pct);
      script_entry_type e;
      e = blank_entry(K_IDLE);
      e.idle_pct = pct;
      pending_script = {pending_script, e};
   endtask

   // Random register setting. Long tours get a small pass limit so that their
   // runs stay short.
   task automatic queue_random_setting();
      logic [15:0] passes;
      logic [15:0] len;
      case ($urandom_range(9))
         0: len = 16'($urandom_range(127, 33));
         1: len = 16'($urandom_range(3, 0));
         default: len = 16'($urandom_range(12, 4));
      endcase
      if (len > 12) passes = 16'($urandom_range(3));
      else if ($urandom_range(3) == 0) passes = 16'($urandom);
      else passes = 16'($urandom_range(6));
      queue_setting(passes, len);
   endtask

   // A stretch of random commands, mostly well-formed load-and-run sequences.
   task automatic queue_random_block(int count);
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0, 1, 2: queue_distance(6'($urandom_range(35)), 6'($urandom_range(35)),
                                    16'($urandom));
            3, 4, 5: queue_tour(6'($urandom_range(40)), random_city());
            6: queue_distance(6'($urandom), 6'($urandom), 16'($urandom));
            7: queue_command(OP_NONE, 6'd0, 6'd0, 16'd0, 6'd0, 6'd0);
            default: queue_run();
         endcase
      end
      queue_run();
   endtask

   // Driver: pops the script and drives the ports at the rising edge. A
   // command stays on the ports until the block takes it.
   int  sender_idle_pct = 0;
   int  quiet_cycles = 0;
   always @(posedge clock) begin
      logic        next_start;
      logic        next_we;
      script_entry_type e;
      next_start = start && busy;
      next_we = 1'b0;
      if (reset) begin
         next_start = 1'b0;
         quiet_cycles = 0;
      end else if (!next_start && pending_script.size() != 0) begin
         e = pending_script[0];
         case (e.kind)
            K_IDLE: begin
               sender_idle_pct = e.idle_pct;
               void'(pending_script.pop_front());
            end
            K_DRAIN: begin
               // The block must stay idle, with nothing owed, for the whole quiet count.
               if (!start && !busy && !rsp_valid && expected_tour.size() == 0)
                  quiet_cycles++;
               else
                  quiet_cycles = 0;
               if (quiet_cycles >= SETTLE_CYCLES) begin
                  quiet_cycles = 0;
                  void'(pending_script.pop_front());
               end
            end
            K_CSR: begin
               next_we = 1'b1;
               csr_index <= e.csr_idx;
               csr_wdata <= e.csr_data;
               void'(pending_script.pop_front());
            end
            default: begin
               if ($urandom_range(99) >= sender_idle_pct) begin
                  next_start = 1'b1;
                  req_opcode <= e.opcode;
                  req_row_city <= e.row_city;
                  req_col_city <= e.col_city;
                  req_dist_value <= e.dist_value;
                  req_tour_pos <= e.tour_pos;
                  req_tour_city <= e.tour_city;
                  void'(pending_script.pop_front());
               end
            end
         endcase
      end
      start <= next_start;
      csr_we <= next_we;
   end

   // Monitor: samples both channels at the rising edge, updates the shadow
   // state and checks every tour beat against the oldest expectation.
   int stall_cycles = 0;
   always @(posedge clock) begin
      tour_beat_type want;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_MAX_PASSES) max_passes_shadow = csr_wdata;
            else tour_len_shadow = csr_wdata[6:0];
         end
         if (start && !busy)
            apply_command(req_opcode, req_row_city, req_col_city, req_dist_value,
                          req_tour_pos, req_tour_city);
         if (rsp_valid) begin
            if (expected_tour.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat pos=%0d city=%0d last=%0b", $realtime,
                        rsp_out_pos, rsp_out_city, rsp_last);
            end else begin
               want = expected_tour.pop_front();
               if (rsp_out_pos !== want.pos) begin
                  mismatch_count++;
                  $display("%0t: out_pos expected %0d actual %0d", $realtime, want.pos,
                           rsp_out_pos);
               end
               if (rsp_out_city !== want.city) begin
                  mismatch_count++;
                  $display("%0t: out_city at pos %0d expected %0d actual %0d", $realtime,
                           want.pos, want.city, rsp_out_city);
               end
               if (rsp_last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: last at pos %0d expected %0b actual %0b", $realtime,
                           want.pos, want.last, rsp_last);
               end
            end
         end
         // Watchdog on any accepted beat or register write.
         if ((start && !busy) || rsp_valid || csr_we) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      // Phase one: the sender idles about a quarter of the time.
      queue_idle(24);
      // Setup: the matrix corner that tours visit and every tour slot, so that
      // no search ever reads storage that was never written.
      for (int a = 0; a < USED_CITIES; a++)
         for (int b = a; b < USED_CITIES; b++)
            queue_distance(6'(a), 6'(b), 16'($urandom_range(1000)));
      for (int p = 0; p < TOUR_SLOTS; p++) queue_tour(6'(p), random_city());

      // Directed part: field extremes and the corner cases.
      queue_distance(6'd0, 6'd5, 16'hFFFF);             // largest distance
      queue_distance(6'd1, 6'd2, 16'h0000);             // smallest distance
      queue_command(OP_DIST, 6'd63, 6'd0, 16'h1234, 6'd0, 6'd0); // row outside the matrix
      queue_command(OP_DIST, 6'd5, 6'd32, 16'h4321, 6'd0, 6'd0); // column outside the matrix
      queue_tour(6'd33, 6'd7);                          // position beyond the tour store
      queue_tour(6'd63, 6'd63);                         // largest position, ignored
      queue_tour(6'd3, 6'd63);                          // city beyond the matrix
      queue_tour(6'd4, 6'd0);
      queue_command(OP_NONE, 6'd63, 6'd63, 16'hFFFF, 6'd63, 6'd63); // unused opcode
      queue_run();                                      // reset setting, full tour
      queue_setting(16'd5, 16'd0);                      // empty tour
      queue_run();
      queue_setting(16'd5, 16'd1);                      // shortest tours
      queue_run();
      queue_setting(16'd5, 16'd3);
      queue_run();
      queue_setting(16'd0, 16'd8);                      // zero passes
      queue_run();
      queue_setting(16'hFFFF, 16'd7);                   // largest pass limit
      queue_run();
      queue_setting(16'd1, 16'd64);                     // long tour, saturated
      queue_run();
      queue_setting(16'd2, 16'd127);                    // every length bit set
      queue_run();
      queue_setting(16'd4, 16'd4);                      // smallest tour with a pair
      queue_run();

      // Random part over three phases with a fresh setting in each.
      queue_random_setting();
      queue_random_block(3);
      // Phase two: the sender is mostly idle.
      queue_setting(16'd3, 16'd9);
      queue_idle(85);
      queue_random_setting();
      queue_random_block(3);
      // Phase three: back to back.
      queue_setting(16'd10, 16'd33);
      queue_idle(0);
      queue_run();
      queue_random_setting();
      queue_random_block(3);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_script.size() != 0 || start || busy || expected_tour.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_tour.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

FILE: two_opt_tour_refiner.f
+incdir+rtl
rtl/toptr_pkg.sv
rtl/toptr_ram.sv
rtl/toptr_ctrl.sv
rtl/toptr_dp.sv
rtl/two_opt_tour_refiner.sv
test/testbench.sv
